>>> hdl/crc8_radio_frame_builder_unit_macros.svh
// ----------------------------------------------------------------------------
// crc8_radio_frame_builder_unit_macros
// Assertion macros shared by the frame builder RTL.
// ----------------------------------------------------------------------------
`ifndef CRC8_RADIO_FRAME_BUILDER_UNIT_MACROS_SVH
`define CRC8_RADIO_FRAME_BUILDER_UNIT_MACROS_SVH

// Same-cycle implication, checked on clk, off while in reset.
`define CRFB_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("frame builder check failed");

// Next-cycle implication, checked on clk, off while in reset.
`define CRFB_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("frame builder check failed");

`endif

>>> hdl/crfb_pkg.sv
// ----------------------------------------------------------------------------
// crfb_pkg
// Types, constants and the CRC-8 byte update for the radio frame builder.
// ----------------------------------------------------------------------------
package crfb_pkg;

	localparam int unsigned MAX_PAYLOAD = 243;

	localparam logic [7:0] CRC_POLY = 8'h07;
	localparam logic [7:0] SYNC_A   = 8'hAA;
	localparam logic [7:0] SYNC_B   = 8'h55;

	// Frame byte positions; one input item walks a subrange of these.
	localparam logic [3:0] POS_SYNC_A0 = 4'd0;
	localparam logic [3:0] POS_SYNC_B0 = 4'd1;
	localparam logic [3:0] POS_LEN_HI  = 4'd2;
	localparam logic [3:0] POS_LEN_LO  = 4'd3;
	localparam logic [3:0] POS_TS3     = 4'd4;
	localparam logic [3:0] POS_TS2     = 4'd5;
	localparam logic [3:0] POS_TS1     = 4'd6;
	localparam logic [3:0] POS_TS0     = 4'd7;
	localparam logic [3:0] POS_KIND    = 4'd8;
	localparam logic [3:0] POS_PAYLOAD = 4'd9;
	localparam logic [3:0] POS_CRC     = 4'd10;
	localparam logic [3:0] POS_SYNC_B1 = 4'd11;
	localparam logic [3:0] POS_SYNC_A1 = 4'd12;
	localparam logic [3:0] POS_DONE    = 4'd13;

	typedef struct packed {
		logic [7:0]  payload_byte;
		logic        has_byte;
		logic        first_item;
		logic        last_item;
		logic [7:0]  payload_count;
		logic [31:0] stamp;
		logic [7:0]  frame_kind;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_end;
		logic       frame_end;
	} out_item_t;

	function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] v;
		v = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			v = v[7] ? ((v << 1) ^ CRC_POLY) : (v << 1);
		end
		return v;
	endfunction

endpackage

>>> hdl/crc8_radio_frame_builder_unit.sv
// ----------------------------------------------------------------------------
// crc8_radio_frame_builder_unit
// Streams payload items into AA 55 | LEN | TS | KIND | payload | CRC8 | 55 AA.
// ----------------------------------------------------------------------------
//  channel | handshake             | payload
//  --------+-----------------------+---------------------------------------
//  input   | in_valid / in_ready   | in_data  (in_item_t), one item a beat
//  output  | out_valid / out_ready | out_data (out_item_t), one byte a beat
//
//  An item sits in the stage register and emits one frame byte per cycle into
//  the output register while not stalled: 9 bytes for a header, 1 for a payload
//  byte, 3 for the trailer, up to 13 for a first-and-last item; an item with
//  no bytes emits none; the stage reloads in the cycle its last byte goes out.
//  Reset (arst_n low) empties both registers and closes any open frame.
//  Output stalls hold the output register and, through it, the stage.
// ----------------------------------------------------------------------------
`include "crc8_radio_frame_builder_unit_macros.svh"

module crc8_radio_frame_builder_unit
	import crfb_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);

	in_item_t   item_s1;
	logic       valid_s1;
	logic [3:0] pos_s1;

	logic       out_valid_q;
	out_item_t  out_data_q;

	logic [7:0] crc_q;
	logic       in_frame_q;

	logic [3:0]  start_pos;
	logic [3:0]  next_pos;
	logic        live;
	logic        drop;
	logic        emit;
	logic        item_done;
	logic [16:0] count_sat;
	logic [15:0] frame_len;
	logic [7:0]  cur_byte;
	logic        cur_crc;

	// Where a fresh item starts in the frame byte sequence.
	always_comb begin
		if (in_data.first_item) begin
			start_pos = POS_SYNC_A0;
		end else if (in_data.has_byte) begin
			start_pos = POS_PAYLOAD;
		end else if (in_data.last_item) begin
			start_pos = POS_CRC;
		end else begin
			start_pos = POS_DONE;
		end
	end

	always_comb begin
		case (pos_s1)
			POS_KIND: begin
				if (item_s1.has_byte) begin
					next_pos = POS_PAYLOAD;
				end else if (item_s1.last_item) begin
					next_pos = POS_CRC;
				end else begin
					next_pos = POS_DONE;
				end
			end
			POS_PAYLOAD: next_pos = item_s1.last_item ? POS_CRC : POS_DONE;
			POS_SYNC_A1: next_pos = POS_DONE;
			POS_DONE:    next_pos = POS_DONE;
			default:     next_pos = pos_s1 + 4'd1;
		endcase
	end

	always_comb begin
		if ({9'd0, item_s1.payload_count} > 17'(MAX_PAYLOAD)) begin
			count_sat = 17'(MAX_PAYLOAD);
		end else begin
			count_sat = {9'd0, item_s1.payload_count};
		end
		frame_len = 16'(count_sat + 17'd5);
	end

	always_comb begin
		cur_crc = 1'b0;
		case (pos_s1)
			POS_SYNC_A0: cur_byte = SYNC_A;
			POS_SYNC_B0: cur_byte = SYNC_B;
			POS_LEN_HI:  cur_byte = frame_len[15:8];
			POS_LEN_LO:  cur_byte = frame_len[7:0];
			POS_TS3: begin
				cur_byte = item_s1.stamp[31:24];
				cur_crc  = 1'b1;
			end
			POS_TS2: begin
				cur_byte = item_s1.stamp[23:16];
				cur_crc  = 1'b1;
			end
			POS_TS1: begin
				cur_byte = item_s1.stamp[15:8];
				cur_crc  = 1'b1;
			end
			POS_TS0: begin
				cur_byte = item_s1.stamp[7:0];
				cur_crc  = 1'b1;
			end
			POS_KIND: begin
				cur_byte = item_s1.frame_kind;
				cur_crc  = 1'b1;
			end
			POS_PAYLOAD: begin
				cur_byte = item_s1.payload_byte;
				cur_crc  = 1'b1;
			end
			POS_CRC:     cur_byte = crc_q;
			POS_SYNC_B1: cur_byte = SYNC_B;
			POS_SYNC_A1: cur_byte = SYNC_A;
			default:     cur_byte = 8'h00;
		endcase
	end

	// Payload and trailer bytes only go out while a frame is open.
	assign live      = valid_s1 && (pos_s1 != POS_DONE)
	                   && ((pos_s1 < POS_PAYLOAD) || in_frame_q);
	assign drop      = valid_s1 && !live;
	assign emit      = live && (!out_valid_q || out_ready);
	assign item_done = drop || (emit && (next_pos == POS_DONE));
	assign in_ready  = !valid_s1 || item_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			pos_s1   <= POS_DONE;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
			pos_s1   <= start_pos;
		end else if (emit) begin
			pos_s1 <= next_pos;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q      <= 8'h00;
			in_frame_q <= 1'b0;
		end else if (emit) begin
			if (pos_s1 == POS_SYNC_A0) begin
				crc_q      <= 8'h00;
				in_frame_q <= 1'b1;
			end else if (pos_s1 == POS_SYNC_A1) begin
				crc_q      <= 8'h00;
				in_frame_q <= 1'b0;
			end else if (cur_crc) begin
				crc_q <= crc8_update(crc_q, cur_byte);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_data_q.out_byte  <= cur_byte;
			out_data_q.run_end   <= (next_pos == POS_DONE);
			out_data_q.frame_end <= (pos_s1 == POS_SYNC_A1);
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// Trailer AA always closes its item's run.
	`CRFB_ASSERT_IMPL(a_frame_end_run_end, out_valid_q && out_data_q.frame_end, out_data_q.run_end)
	// A busy stage that does not finish keeps its item.
	`CRFB_ASSERT_NEXT(a_stage_holds, valid_s1 && !item_done, valid_s1 && $stable(item_s1))
	// Emitting the closing AA closes the frame.
	`CRFB_ASSERT_NEXT(a_trailer_closes, emit && (pos_s1 == POS_SYNC_A1), !in_frame_q && (crc_q == 8'h00))
	// Header start opens the frame.
	`CRFB_ASSERT_NEXT(a_header_opens, emit && (pos_s1 == POS_SYNC_A0), in_frame_q)

endmodule
